// ===== hdl/fir72_pkg.sv =====
// Package for the 72-tap FIR filter: widths, coefficient table and shared types.
package fir72_pkg;

   // Field widths
   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 16;
   localparam int PROD_W   = SAMPLE_W + COEF_W;
   localparam int OUT_W    = 18;
   localparam int FRAC_W   = 15;

   // Default tap count
   localparam int TAPS_DEF = 72;

   // Coefficient table size (symmetric, only the first half is stored)
   localparam int COEF_COUNT = 72;
   localparam int COEF_HALF  = 36;

   // Output saturation limits, Q3.15
   localparam logic signed [OUT_W-1:0] OUT_MAX = 18'sh1FFFF;
   localparam logic signed [OUT_W-1:0] OUT_MIN = 18'sh20000;

   // Lowpass coefficients, Q1.15, c[0] .. c[35]
   localparam logic signed [COEF_W-1:0] COEF_HALF_TABLE [COEF_HALF] = '{
        16'sd406,   16'sd662,    16'sd16,  -16'sd234,    16'sd93,   16'sd171,
       -16'sd230,    -16'sd7,   16'sd243,  -16'sd143,  -16'sd187,   16'sd289,
         16'sd22,  -16'sd341,   16'sd192,   16'sd270,  -16'sd397,   -16'sd56,
        16'sd496,  -16'sd255,  -16'sd416,   16'sd570,   16'sd121,  -16'sd760,
        16'sd354,   16'sd693,  -16'sd902,  -16'sd265,  16'sd1345,  -16'sd583,
      -16'sd1445,  16'sd1915,   16'sd813, -16'sd4157,  16'sd2247, 16'sd16811
   };

   // Coefficient of tap k; taps past the table have a zero coefficient
   function automatic logic signed [COEF_W-1:0] coef_at(input int k);
      logic signed [COEF_W-1:0] c;
      if (k >= COEF_COUNT) begin
         c = '0;
      end else if (k < COEF_HALF) begin
         c = COEF_HALF_TABLE[k];
      end else begin
         c = COEF_HALF_TABLE[COEF_COUNT - 1 - k];
      end
      return c;
   endfunction

   // Control broadcast to every tap cell
   typedef struct packed {
      logic advance;  // a sample beat is taken this cycle
      logic clear;    // that beat zeroes the history first
   } step_type;

endpackage

// ===== hdl/fir72_if.sv =====
// Stream interfaces for the sample and result channels of the FIR filter.
interface fir72_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [fir72_pkg::SAMPLE_W-1:0]  sample;
   logic                                   clear;

   modport source (output valid, output sample, output clear, input ready);
   modport sink   (input valid, input sample, input clear, output ready);
endinterface

interface fir72_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [fir72_pkg::OUT_W-1:0]     filtered;

   modport source (output valid, output filtered, input ready);
   modport sink   (input valid, input filtered, output ready);
endinterface

// ===== hdl/fir72_tap_cell.sv =====
// One tap of the transposed FIR chain: multiply-add into a partial sum register.
module fir72_tap_cell #(
   parameter int                                    ACC_W = 40,
   parameter logic signed [fir72_pkg::COEF_W-1:0]   COEF  = '0
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  fir72_pkg::step_type                      step,
   input  logic signed [fir72_pkg::SAMPLE_W-1:0]    sample,
   input  logic signed [ACC_W-1:0]                  sum_next,
   output logic signed [ACC_W-1:0]                  sum
);

   logic signed [fir72_pkg::PROD_W-1:0] product;
   logic signed [ACC_W-1:0]             product_ext;
   logic signed [ACC_W-1:0]             carry_in;
   logic signed [ACC_W-1:0]             sum_ff;
   logic signed [ACC_W-1:0]             sum_in;

   // Tap product, sign extended to the accumulator width
   assign product     = sample * COEF;
   assign product_ext = {{(ACC_W-fir72_pkg::PROD_W){product[fir72_pkg::PROD_W-1]}}, product};

   // A clear drops the partial sum coming from the older taps
   assign carry_in = step.clear ? '0 : sum_next;

   always_comb begin
      sum_in = sum_ff;
      if (step.advance) begin
         sum_in = product_ext + carry_in;
      end
   end

   // Partial sum register; reset means an all-zero history
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

// ===== hdl/fir72_out_stage.sv =====
// Head tap, rounding, saturation and the output register of the FIR filter.
module fir72_out_stage #(
   parameter int                                    ACC_W = 40,
   parameter logic signed [fir72_pkg::COEF_W-1:0]   COEF  = '0
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  fir72_pkg::step_type                      step,
   input  logic signed [fir72_pkg::SAMPLE_W-1:0]    sample,
   input  logic signed [ACC_W-1:0]                  sum_next,
   input  logic                                     out_ready,
   output logic                                     out_valid,
   output logic signed [fir72_pkg::OUT_W-1:0]       filtered,
   output logic                                     in_ready
);

   localparam int RND_W = ACC_W + 1;
   localparam int SHR_W = RND_W - fir72_pkg::FRAC_W;
   localparam logic signed [RND_W-1:0] ROUND_BIAS = RND_W'(1) <<< (fir72_pkg::FRAC_W - 1);

   logic signed [fir72_pkg::PROD_W-1:0]  product;
   logic signed [ACC_W-1:0]              acc;
   logic signed [RND_W-1:0]              biased;
   logic signed [SHR_W-1:0]              rounded;
   logic                                 overflow;
   logic signed [fir72_pkg::OUT_W-1:0]   filtered_in;
   logic signed [fir72_pkg::OUT_W-1:0]   filtered_ff;
   logic                                 valid_in;
   logic                                 valid_ff;

   // Full sum: current sample times the first coefficient plus the chain
   assign product = sample * COEF;
   assign acc = {{(ACC_W-fir72_pkg::PROD_W){product[fir72_pkg::PROD_W-1]}}, product}
                + (step.clear ? '0 : sum_next);

   // Round to nearest, halves up, by FRAC_W bits
   assign biased  = {acc[ACC_W-1], acc} + ROUND_BIAS;
   assign rounded = SHR_W'(biased >>> fir72_pkg::FRAC_W);

   // Out of range when the bits above the output width are not a sign run
   assign overflow = (rounded[SHR_W-1:fir72_pkg::OUT_W-1] != '0) &&
                     (rounded[SHR_W-1:fir72_pkg::OUT_W-1] != '1);

   always_comb begin
      if (overflow) begin
         filtered_in = rounded[SHR_W-1] ? fir72_pkg::OUT_MIN : fir72_pkg::OUT_MAX;
      end else begin
         filtered_in = rounded[fir72_pkg::OUT_W-1:0];
      end
   end

   // Output register: loads on a sample beat, empties when taken
   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (step.advance) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step.advance) begin
         filtered_ff <= filtered_in;
      end
   end

   assign out_valid = valid_ff;
   assign filtered  = filtered_ff;

endmodule

// ===== hdl/fir_filter_72_tap.sv =====
// Top level of the streaming 72-tap symmetric lowpass FIR filter.
// Streaming FIR filter in transposed form: each accepted sample beat (signed Q1.15)
// gives one result beat, the sum of the current and last TAPS-1 samples times the
// fixed lowpass coefficients, rounded to nearest by 15 bits and saturated to Q3.15.
// One sample is taken per clock; when the result beat is not taken, the whole tap
// chain holds and the sample channel stalls until the output register frees up.
// Every tap cell does its multiply-add in the cycle the sample is taken, so the
// result appears in the output register in the cycle after the sample beat. A beat
// with clear set zeroes the history before its sample is used. Feed zero samples to
// flush the tail. Reset zeroes the history at once; no clearing pass is needed.
module fir_filter_72_tap #(
   parameter int TAPS = fir72_pkg::TAPS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   fir72_req_if.sink        req_bus,
   fir72_rsp_if.source      rsp_bus
);

   localparam int ACC_W = fir72_pkg::PROD_W + $clog2(TAPS);

   fir72_pkg::step_type       step;
   logic                      in_ready;
   logic signed [ACC_W-1:0]   tap_sum [1:TAPS];

   // A sample beat moves the whole chain
   assign step.advance = req_bus.valid && in_ready;
   assign step.clear   = req_bus.clear;
   assign req_bus.ready = in_ready;

   // Oldest tap has nothing behind it
   assign tap_sum[TAPS] = '0;

   // Row of tap cells, each holding one partial sum
   for (genvar k = 1; k < TAPS; k++) begin : g_tap
      fir72_tap_cell #(
         .ACC_W (ACC_W),
         .COEF  (fir72_pkg::coef_at(k))
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .step     (step),
         .sample   (req_bus.sample),
         .sum_next (tap_sum[k+1]),
         .sum      (tap_sum[k])
      );
   end

   // Head tap and output register
   fir72_out_stage #(
      .ACC_W (ACC_W),
      .COEF  (fir72_pkg::coef_at(0))
   ) u_out (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .sample    (req_bus.sample),
      .sum_next  (tap_sum[1]),
      .out_ready (rsp_bus.ready),
      .out_valid (rsp_bus.valid),
      .filtered  (rsp_bus.filtered),
      .in_ready  (in_ready)
   );

endmodule

// ===== hdl/fir72_checker.sv =====
// Port-level checks for the FIR filter, bound to its top level.
module fir72_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic signed [fir72_pkg::SAMPLE_W-1:0] req_sample,
   input logic                                 req_clear,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [fir72_pkg::OUT_W-1:0]   rsp_filtered
);

   // Output register is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Every sample beat yields a result beat in the next cycle
   a_beat_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("sample beat without result");

   // An empty output register never stalls the sample side
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("stall with empty output");

   // A pending result stays until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_filtered))
      else $error("pending result dropped or changed");

   // Clear with a zero sample gives a zero result
   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_clear && (req_sample == '0)) |=> (rsp_filtered == '0))
      else $error("clear with zero sample gave nonzero result");

endmodule

bind fir_filter_72_tap fir72_checker u_fir72_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .req_sample   (req_bus.sample),
   .req_clear    (req_bus.clear),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_filtered (rsp_bus.filtered)
);
